@@ sv/dtps_pkg.sv @@
// dtps_pkg: shared types, geometry constants and codes for the depth-tested pixel store.
// No dependencies; imported by every module of the block.
package dtps_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int COORD_W       = (SCREEN_MAX > 1) ? $clog2(SCREEN_MAX) : 1;
    localparam int PROD_W        = 2 * COORD_W + 1;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 32;

    localparam logic [7:0] CLEAR_BASE  = 8'b1010_0000;
    localparam logic [4:0] OPAQUE_COLOR = 5'd31;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X    = 4'd0,
        CFG_CAMERA_Y    = 4'd1,
        CFG_CLIP_LEFT   = 4'd2,
        CFG_CLIP_TOP    = 4'd3,
        CFG_CLIP_RIGHT  = 4'd4,
        CFG_CLIP_BOTTOM = 4'd5,
        CFG_DRAW_DEPTH  = 4'd6,
        CFG_TMASK       = 4'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [4:0]         color;
    } item_t;

    typedef struct packed {
        logic [4:0] read_color;
        logic       written;
    } result_t;

    typedef struct packed {
        logic signed [15:0] camera_x;
        logic signed [15:0] camera_y;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
        logic [2:0]         draw_depth;
        logic [31:0]        tmask;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

endpackage

@@ sv/dtps_cfg.sv @@
// dtps_cfg: configuration register file written through a valid/ready channel.
// Depends on dtps_pkg.
module dtps_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtps_pkg::CFG_DATA_W-1:0] cfg_data,
    output dtps_pkg::cfg_t                 cfg
);
    import dtps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CAMERA_X:    cfg_next.camera_x    = cfg_data[15:0];
                CFG_CAMERA_Y:    cfg_next.camera_y    = cfg_data[15:0];
                CFG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data[15:0];
                CFG_CLIP_TOP:    cfg_next.clip_top    = cfg_data[15:0];
                CFG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data[15:0];
                CFG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data[15:0];
                CFG_DRAW_DEPTH:  cfg_next.draw_depth  = cfg_data[2:0];
                CFG_TMASK:       cfg_next.tmask       = cfg_data[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x    <= '0;
            cfg_reg.camera_y    <= '0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= 16'(SCREEN_WIDTH);
            cfg_reg.clip_bottom <= 16'(SCREEN_HEIGHT);
            cfg_reg.draw_depth  <= '0;
            cfg_reg.tmask       <= 32'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/dtps_ram.sv @@
// dtps_ram: pixel memory, one write port and one read port with registered read data.
// Depends on dtps_pkg.
module dtps_ram (
    input  logic                        clk,
    input  dtps_pkg::ram_wr_t           wr,
    input  logic                        rd_en,
    input  logic [dtps_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import dtps_pkg::*;

    logic [7:0] mem [PIXEL_COUNT];
    logic [7:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ sv/dtps_ctrl.sv @@
// dtps_ctrl: command sequencer; bounds checks, depth test read-modify-write and clear sweep.
// Depends on dtps_pkg; drives dtps_ram.
module dtps_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dtps_pkg::item_t             item,
    input  dtps_pkg::cfg_t              cfg,
    output logic                        done,
    output dtps_pkg::result_t           result,
    output dtps_pkg::ram_wr_t           wr,
    output logic                        rd_en,
    output logic [dtps_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                  rd_data
);
    import dtps_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]         fill_reg;
    op_t                op_reg;
    logic [4:0]         color_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic               accept;
    logic               last;
    logic signed [16:0] sx, sy, rx, ry;
    logic               w_hit, r_hit;
    logic [ADDR_W-1:0]  w_addr, r_addr;
    logic [PROD_W-1:0]  w_prod, r_prod;
    logic [2:0]         old_depth;
    logic               depth_ok;
    logic               transp;
    logic [7:0]         new_pix;

    function automatic logic on_screen(logic signed [16:0] px, logic signed [16:0] py);
        return (px >= 17'sd0) && (px < $signed(17'(SCREEN_WIDTH)))
            && (py >= 17'sd0) && (py < $signed(17'(SCREEN_HEIGHT)));
    endfunction

    function automatic logic [ADDR_W-1:0] pix_addr(logic signed [16:0] px,
                                                   logic signed [16:0] py);
        logic [PROD_W-1:0] p;
        p = PROD_W'(py[COORD_W-1:0]) * PROD_W'(SCREEN_WIDTH) + PROD_W'(px[COORD_W-1:0]);
        return p[ADDR_W-1:0];
    endfunction

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign last   = (cnt_reg == LAST_ADDR);

    assign sx = 17'(item.x) - 17'(cfg.camera_x);
    assign sy = 17'(item.y) - 17'(cfg.camera_y);
    assign rx = 17'(item.x);
    assign ry = 17'(item.y);

    assign w_hit = on_screen(sx, sy)
                && (sx >= 17'(cfg.clip_left)) && (sx < 17'(cfg.clip_right))
                && (sy >= 17'(cfg.clip_top))  && (sy < 17'(cfg.clip_bottom));
    assign r_hit = on_screen(rx, ry);
    assign w_prod = '0;
    assign r_prod = w_prod;
    assign w_addr = pix_addr(sx, sy);
    assign r_addr = pix_addr(rx, ry) | r_prod[ADDR_W-1:0];

    assign rd_en   = accept;
    assign rd_addr = (item.op == OP_WRITE) ? w_addr : r_addr;

    assign old_depth = rd_data[7:5];
    assign depth_ok  = old_depth[2] || (old_depth <= cfg.draw_depth);
    assign transp    = (color_reg != OPAQUE_COLOR) && cfg.tmask[color_reg];
    // transparent flag shares bit 5 with the depth field
    assign new_pix   = {cfg.draw_depth, 5'b0} | {2'b0, transp, 5'b0} | {3'b0, color_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:   if (last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.op == OP_CLEAR) ? ST_CLEAR : ST_ACCESS;
                end
            end
            ST_ACCESS: state_next = ST_IDLE;
            ST_CLEAR:  if (last) state_next = ST_IDLE;
            default:   state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        wr          = '0;
        done_next   = 1'b0;
        result_next = '0;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                wr.en     = 1'b1;
                wr.addr   = cnt_reg;
                wr.data   = fill_reg;
                cnt_next  = last ? '0 : cnt_reg + 1'b1;
                done_next = last && (state_reg == ST_CLEAR);
            end
            ST_ACCESS:
            begin
                wr.en     = (op_reg == OP_WRITE) && hit_reg && depth_ok;
                wr.addr   = addr_reg;
                wr.data   = new_pix;
                done_next = 1'b1;
                result_next.written    = wr.en;
                result_next.read_color = ((op_reg == OP_READ) && hit_reg) ? rd_data[4:0] : 5'd0;
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            cnt_reg    <= '0;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (accept && (item.op == OP_CLEAR))
            begin
                fill_reg <= CLEAR_BASE | {3'b0, item.color};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= item.op;
            color_reg <= item.color;
            hit_reg   <= (item.op == OP_WRITE) ? w_hit : r_hit;
            addr_reg  <= rd_addr;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/depth_tested_pixel_store.sv @@
// depth_tested_pixel_store: top level; byte-per-pixel canvas with depth test and clipping.
// Depends on dtps_pkg, dtps_cfg, dtps_ram, dtps_ctrl.
//
// Commands are taken when start is high and busy is low; every command gives
// exactly one result, shown on result for one cycle with done high, and the
// receiver cannot stall it. For reads, writes and the unused op code the
// pixel memory's registered read port returns the stored byte in the cycle
// after acceptance, the depth test and write-back happen in that cycle, and
// done rises the cycle after, when the next command may already be accepted.
// A clear sweeps the memory one pixel per cycle, with done in the cycle after
// the last pixel. After reset the same sweep writes zeros, so busy stays high
// until that sweep ends; configuration writes are taken at any time, but
// should only be issued while the block is idle.
module depth_tested_pixel_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dtps_pkg::item_t                item,
    output logic                           done,
    output dtps_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dtps_pkg::*;

    cfg_t              cfg;
    ram_wr_t           wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    dtps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtps_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dtps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .cfg     (cfg),
        .done    (done),
        .result  (result),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

@@ sv/dtps_checker.sv @@
// dtps_checker: port-level assertions for depth_tested_pixel_store, bound to the top level.
// Depends on dtps_pkg.
module dtps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input dtps_pkg::item_t   item,
    input logic              done,
    input dtps_pkg::result_t result
);
    import dtps_pkg::*;

    // an accepted transaction keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

    // reads and writes complete with done after the access state
    a_access_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.op == OP_READ || item.op == OP_WRITE) |=> ##1 done)
        else $error("read or write result missing");

    // a read never reports a write
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.op == OP_READ) |=> ##1 !result.written)
        else $error("read reported as written");

endmodule

bind depth_tested_pixel_store dtps_checker u_dtps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
